// File: src/ows_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
// Used by ows_engine and onewire_rom_search_engine; no dependencies.
package ows_pkg;

  localparam int unsigned RomBits     = 64;
  localparam int unsigned PosW        = 7;
  localparam int unsigned FamW        = 4;
  localparam logic [PosW-1:0] EndPos      = PosW'(65);
  localparam logic [PosW-1:0] FamilyLimit = PosW'(9);
  localparam logic [PosW-1:0] FirstPos    = PosW'(1);
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 88;

  typedef enum logic {
    REQ_BEGIN   = 1'b0,
    REQ_TRIPLET = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t req_type;
    logic      first_search;
    logic      presence;
    logic      id_bit;
    logic      comp_bit;
    logic      dir_taken;
  } ows_item_t;

  typedef struct packed {
    logic                protocol_error;
    logic [FamW-1:0]     family_discrepancy;
    logic [RomBits-1:0]  rom_code;
    logic                last_device;
    logic                device_found;
    logic                done_res;
    logic                busy_res;
    logic [PosW-1:0]     next_bit_index;
    logic                next_direction;
  } ows_result_t;

endpackage

// File: src/ows_engine.sv
// Search state and single-pass step logic for the 1-Wire ROM search engine.
// Depends on ows_pkg for the item and result types.
module ows_engine
  import ows_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  ows_item_t   item,
  output ows_result_t result
);

  logic [RomBits-1:0] rom_bits_r, rom_bits_nxt;
  logic [PosW-1:0]    last_disc_r, last_disc_nxt;
  logic               last_dev_flag_r, last_dev_flag_nxt;
  logic [FamW-1:0]    family_disc_r, family_disc_nxt;
  logic [PosW-1:0]    bit_pos_r, bit_pos_nxt;
  logic [PosW-1:0]    last_zero_r, last_zero_nxt;
  logic               searching_r, searching_nxt;

  logic [PosW-1:0]    pos_inc;
  logic [PosW-1:0]    idx_sel;
  logic [5:0]         bit_sel;
  logic [5:0]         out_sel;
  logic               done;
  logic               found;
  logic               lastdev;
  logic               perr;
  logic               wanted;

  assign bit_sel = 6'(bit_pos_r - FirstPos);
  assign pos_inc = bit_pos_r + FirstPos;

  always_comb begin
    rom_bits_nxt      = rom_bits_r;
    last_disc_nxt     = last_disc_r;
    last_dev_flag_nxt = last_dev_flag_r;
    family_disc_nxt   = family_disc_r;
    bit_pos_nxt       = bit_pos_r;
    last_zero_nxt     = last_zero_r;
    searching_nxt     = searching_r;
    done              = 1'b0;
    found             = 1'b0;
    lastdev           = 1'b0;
    perr              = 1'b0;
    case (item.req_type)
      REQ_BEGIN: begin
        if (item.first_search) begin
          last_disc_nxt     = '0;
          last_dev_flag_nxt = 1'b0;
          family_disc_nxt   = '0;
        end
        bit_pos_nxt   = FirstPos;
        last_zero_nxt = '0;
        if (last_dev_flag_nxt || !item.presence) begin
          last_disc_nxt     = '0;
          last_dev_flag_nxt = 1'b0;
          family_disc_nxt   = '0;
          searching_nxt     = 1'b0;
          done              = 1'b1;
        end else begin
          searching_nxt = 1'b1;
        end
      end
      REQ_TRIPLET: begin
        if (!searching_r) begin
          perr = 1'b1;
        end else if (item.id_bit && item.comp_bit) begin
          last_disc_nxt     = '0;
          last_dev_flag_nxt = 1'b0;
          family_disc_nxt   = '0;
          searching_nxt     = 1'b0;
          bit_pos_nxt       = FirstPos;
          last_zero_nxt     = '0;
          done              = 1'b1;
        end else begin
          if (!item.id_bit && !item.comp_bit && !item.dir_taken) begin
            last_zero_nxt = bit_pos_r;
            if (bit_pos_r < FamilyLimit) begin
              family_disc_nxt = FamW'(bit_pos_r);
            end
          end
          rom_bits_nxt[bit_sel] = item.dir_taken;
          if (pos_inc >= EndPos) begin
            done              = 1'b1;
            last_disc_nxt     = last_zero_nxt;
            last_dev_flag_nxt = (last_zero_nxt == '0);
            searching_nxt     = 1'b0;
            bit_pos_nxt       = FirstPos;
            last_zero_nxt     = '0;
            if (rom_bits_nxt[7:0] == 8'h00) begin
              last_disc_nxt     = '0;
              last_dev_flag_nxt = 1'b0;
              family_disc_nxt   = '0;
            end else begin
              found   = 1'b1;
              lastdev = last_dev_flag_nxt;
            end
          end else begin
            bit_pos_nxt = pos_inc;
          end
        end
      end
      default: begin
        perr = 1'b0;
      end
    endcase
  end

  assign out_sel = 6'(bit_pos_nxt - FirstPos);

  always_comb begin
    if (bit_pos_nxt < last_disc_nxt) begin
      wanted = rom_bits_nxt[out_sel];
    end else begin
      wanted = (bit_pos_nxt == last_disc_nxt);
    end
    idx_sel = searching_nxt ? bit_pos_nxt : FirstPos;
  end

  always_comb begin
    result.next_direction     = searching_nxt & wanted;
    result.next_bit_index     = idx_sel;
    result.busy_res           = searching_nxt;
    result.done_res           = done;
    result.device_found       = found;
    result.last_device        = lastdev;
    result.rom_code           = rom_bits_nxt;
    result.family_discrepancy = family_disc_nxt;
    result.protocol_error     = perr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bits_r      <= '0;
      last_disc_r     <= '0;
      last_dev_flag_r <= 1'b0;
      family_disc_r   <= '0;
      bit_pos_r       <= FirstPos;
      last_zero_r     <= '0;
      searching_r     <= 1'b0;
    end else if (step_en) begin
      rom_bits_r      <= rom_bits_nxt;
      last_disc_r     <= last_disc_nxt;
      last_dev_flag_r <= last_dev_flag_nxt;
      family_disc_r   <= family_disc_nxt;
      bit_pos_r       <= bit_pos_nxt;
      last_zero_r     <= last_zero_nxt;
      searching_r     <= searching_nxt;
    end
  end

endmodule

// File: src/onewire_rom_search_engine.sv
// Top level of the 1-Wire ROM search engine: request register, step engine, result register.
// Depends on ows_pkg and ows_engine.
//
//  channel  | ports                        | moves
//  ---------+------------------------------+-------------------------------------
//  request  | in_tvalid/in_tready/in_tdata | begin or triplet status, kind in tuser
//  result   | out_tvalid/out_tready/out_tdata | direction, index, flags, ROM code
//
// One request per cycle unless a result stalls; results come from the result register.
// The step engine advances once per request, between the request and result registers.
// Reset (rst_n low, synchronous) clears the search state, ROM code and both valid flags.
// A stalled result holds in the result register; the request register still takes a
// new request when its content moves on in the same cycle.
module onewire_rom_search_engine
  import ows_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [0] first_search, [1] presence, [2] id_bit, [3] comp_bit, [4] dir_taken, [7:5] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [0] req_type
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] next_direction, [7:1] next_bit_index, [8] busy_res, [9] done_res,
  // [10] device_found, [11] last_device, [75:12] rom_code,
  // [79:76] family_discrepancy, [80] protocol_error, [87:81] zero
  output logic [OutDataW-1:0] out_tdata
);

  logic                in_valid_r;
  ows_item_t           in_item_r;
  logic                out_valid_r;
  ows_result_t         out_res_r;
  ows_result_t         step_res;
  ows_item_t           in_item;
  logic                step_en;
  logic                in_fire;

  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_item.req_type     = req_type_t'(in_tuser);
    in_item.first_search = in_tdata[0];
    in_item.presence     = in_tdata[1];
    in_item.id_bit       = in_tdata[2];
    in_item.comp_bit     = in_tdata[3];
    in_item.dir_taken    = in_tdata[4];
  end

  ows_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_item;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - $bits(ows_result_t))'(0), out_res_r};

endmodule

// File: test/onewire_rom_search_engine_tb.sv
// Testbench for onewire_rom_search_engine: triplet-driven 1-Wire ROM search passes
// are checked against a cycle-free predictor of the search state kept in this file.
// Depends on ows_pkg and the engine RTL; streams requests and results with random stalls.
`timescale 1ns / 1ps

module onewire_rom_search_engine_tb
  import ows_pkg::*;
();

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  logic [RomBits-1:0] srch_rom = '0;
  logic [PosW-1:0]    srch_last_disc = '0;
  logic               srch_done_all = 1'b0;
  logic [FamW-1:0]    srch_family = '0;
  logic [PosW-1:0]    srch_pos = FirstPos;
  logic [PosW-1:0]    srch_zero_pos = '0;
  logic               srch_active = 1'b0;

  ows_result_t expected_results[$];
  int          fails = 0;
  int          items_sent = 0;
  int          rx_wait = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  onewire_rom_search_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic void search_clear();
    srch_last_disc = '0;
    srch_done_all  = 1'b0;
    srch_family    = '0;
    srch_active    = 1'b0;
    srch_pos       = FirstPos;
    srch_zero_pos  = '0;
  endfunction

  function automatic logic want_dir();
    if (srch_pos < srch_last_disc) begin
      return srch_rom[6'(srch_pos - 7'd1)];
    end
    return srch_pos == srch_last_disc;
  endfunction

  function automatic ows_result_t search_step(req_type_t req, logic first, logic pres,
                                              logic idb, logic cmpb, logic dir);
    ows_result_t r;
    logic [PosW-1:0] p;
    r = '0;
    if (req == REQ_BEGIN) begin
      if (first) begin
        srch_last_disc = '0;
        srch_done_all  = 1'b0;
        srch_family    = '0;
      end
      if (srch_done_all || !pres) begin
        search_clear();
        r.done_res = 1'b1;
      end else begin
        srch_active   = 1'b1;
        srch_pos      = FirstPos;
        srch_zero_pos = '0;
      end
    end else if (!srch_active) begin
      r.protocol_error = 1'b1;
    end else if (idb && cmpb) begin
      search_clear();
      r.done_res = 1'b1;
    end else begin
      p = srch_pos;
      if (!idb && !cmpb && !dir) begin
        srch_zero_pos = p;
        if (p < FamilyLimit) srch_family = p[FamW-1:0];
      end
      srch_rom[6'(p - 7'd1)] = dir;
      p = p + 7'd1;
      if (p >= EndPos) begin
        r.done_res     = 1'b1;
        srch_last_disc = srch_zero_pos;
        srch_done_all  = (srch_last_disc == '0);
        if (srch_rom[7:0] == 8'h00) begin
          search_clear();
        end else begin
          r.device_found = 1'b1;
          r.last_device  = srch_done_all;
          srch_active    = 1'b0;
          srch_pos       = FirstPos;
          srch_zero_pos  = '0;
        end
      end else begin
        srch_pos = p;
      end
    end
    r.busy_res           = srch_active;
    r.next_direction     = srch_active ? want_dir() : 1'b0;
    r.next_bit_index     = srch_active ? srch_pos : FirstPos;
    r.rom_code           = srch_rom;
    r.family_discrepancy = srch_family;
    return r;
  endfunction

  task automatic send_req(req_type_t req, logic first, logic pres, logic idb, logic cmpb,
                          logic dir);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, dir, cmpb, idb, pres, first};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(search_step(req, first, pres, idb, cmpb, dir));
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ows_result_t exp_r;
    ows_result_t got_r;
    if (rst_n && out_tvalid && out_tready) begin
      rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
      got_r = out_tdata[$bits(ows_result_t)-1:0];
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result expected none got %0h", $time, out_tdata);
        fails++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("next_direction", exp_r.next_direction, got_r.next_direction);
        check_field("next_bit_index", exp_r.next_bit_index, got_r.next_bit_index);
        check_field("busy_res", exp_r.busy_res, got_r.busy_res);
        check_field("done_res", exp_r.done_res, got_r.done_res);
        check_field("device_found", exp_r.device_found, got_r.device_found);
        check_field("last_device", exp_r.last_device, got_r.last_device);
        check_field("rom_code", exp_r.rom_code, got_r.rom_code);
        check_field("family_discrepancy", exp_r.family_discrepancy,
                    got_r.family_discrepancy);
        check_field("protocol_error", exp_r.protocol_error, got_r.protocol_error);
        check_field("pad", '0, out_tdata[OutDataW-1:$bits(ows_result_t)]);
      end
    end
  end

  task automatic test_idle_triplets();
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_req(REQ_BEGIN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_short_pass();
    send_req(REQ_BEGIN, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
    send_req(REQ_TRIPLET, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic test_restart();
    send_req(REQ_BEGIN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(REQ_BEGIN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_req(REQ_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    wait_drain();
  endtask

  // Enumerate small device populations; the bus ANDs the bits of devices still selected.
  task automatic test_search_passes();
    logic [63:0] dev [4];
    logic [3:0]  alive;
    logic        idb, cmpb, dir, b;
    int          ndev, k, pos0;
    while (items_sent < 1080) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      ndev = $urandom_range(0, 4);
      dev[0] = {$urandom, $urandom};
      if ($urandom_range(0, 5) == 0) dev[0][7:0] = 8'h00;
      for (int d = 1; d < 4; d++) begin
        k = $urandom_range(0, 63);
        dev[d] = dev[0] ^ (64'h1 << k) ^
                 ({$urandom, $urandom} & ~(64'h1 << k) & (~64'h0 << k));
      end
      for (int p = 0; p < ndev + 2 && items_sent < 1080; p++) begin
        send_req(REQ_BEGIN, p == 0 || $urandom_range(0, 7) == 0, $urandom_range(0, 15) != 0,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        alive = 4'((1 << ndev) - 1);
        while (srch_active) begin
          if ($urandom_range(0, 199) == 0) begin
            send_req(REQ_BEGIN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            alive = 4'((1 << ndev) - 1);
          end else begin
            pos0 = srch_pos - 1;
            idb  = 1'b1;
            cmpb = 1'b1;
            for (int d = 0; d < ndev; d++) begin
              if (alive[d]) begin
                b = dev[d][pos0];
                idb  = idb & b;
                cmpb = cmpb & ~b;
              end
            end
            if (idb != cmpb) dir = idb;
            else if (!idb) dir = want_dir();
            else dir = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 63) == 0) {idb, cmpb, dir} = 3'($urandom);
            send_req(REQ_TRIPLET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     idb, cmpb, dir);
            for (int d = 0; d < ndev; d++) begin
              if (dev[d][pos0] != dir) alive[d] = 1'b0;
            end
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          send_req(REQ_TRIPLET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 2) == 0) wait_drain();
    end
  endtask

  initial begin
    search_clear();
    srch_rom = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_triplets();
    test_short_pass();
    test_restart();
    test_search_passes();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: onewire_rom_search_engine.f
src/ows_pkg.sv
src/ows_engine.sv
src/onewire_rom_search_engine.sv
test/onewire_rom_search_engine_tb.sv
